[rtl/ats_pkg.sv]
package ats_pkg;

	localparam int MAX_COMMANDS    = 64;
	localparam int BUFFER_WORDS    = 4096;
	localparam int HEADER_BYTES    = 6;
	localparam int MIN_ENTRY_WORDS = 7;
	localparam int NUM_TABLES_DEF  = 2;

	// widths of the command index, count and word index
	localparam int CIDX_W = $clog2(MAX_COMMANDS);
	localparam int CNT_W  = 7;
	localparam int WRD_W  = 13;
	localparam int CMD_W  = 7;
	localparam int TIME_W = 32;

	typedef enum logic [2:0] {
		ST_ACCEPT  = 3'd0,
		ST_DONE    = 3'd1,
		ST_ERROR   = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_READ    = 3'd4,
		ST_IGNORED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_RD
	} fsm_t;

	localparam logic REG_MIN_BYTES = 1'b0;
	localparam logic REG_MAX_BYTES = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [TIME_W-1:0] tm;
	} key_t;

endpackage

[rtl/ats_ram.sv]
module ats_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/ats_cell.sv]
module ats_cell #(
	parameter int NUM_TABLES = 2
) (
	input  logic                                          clk,
	input  logic                                          ins,
	input  logic [((NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1)-1:0] tbl,
	input  ats_pkg::key_t                                 new_key,
	input  logic                                          occupied,
	input  logic                                          tail,
	input  ats_pkg::key_t                                 left_key,
	input  logic                                          left_gt,
	output ats_pkg::key_t                                 key,
	output logic                                          gt
);
	import ats_pkg::*;

	key_t key_q [NUM_TABLES];

	assign key = key_q[tbl];
	// this slot sorts after the new entry
	assign gt = occupied && ((key.tm > new_key.tm) ||
		((key.tm == new_key.tm) && (key.cmd > new_key.cmd)));

	always_ff @(posedge clk) begin
		if (ins) begin
			if (left_gt) begin
				key_q[tbl] <= left_key;
			end else if (gt || tail) begin
				key_q[tbl] <= new_key;
			end
		end
	end

endmodule

[rtl/ats_load_time_sorted.sv]
// load entry, clear and ignored transactions: result registered from the EXEC state
// read transactions: result after a further RD state, for the offset memory read port
// one transaction at a time; next accepted once the result has been taken
// a new entry is inserted by the row of shifting list slots
// reset: all loads closed, lists empty, min/max packet bytes 8/256
module ats_load_time_sorted #(
	parameter int NUM_TABLES = ats_pkg::NUM_TABLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// cmd_number, packet_bytes, time_tag, position, zero pad
	input  logic [71:0] s_axis_tdata,
	// action, table_select
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// sorted_cmd_number, entry_offset, sorted_time, command_count, load_words
	output logic [71:0] m_axis_tdata,
	// status
	output logic [2:0]  m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import ats_pkg::*;

	localparam int TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int AW = TW + CIDX_W;

	fsm_t st_q, st_d;

	logic [15:0] min_q, max_q;
	logic [1:0]  act_q;
	logic        sel_q;
	logic [15:0] cmd_q, bytes_q;
	logic [31:0] time_q;
	logic [5:0]  pos_q;

	logic [WRD_W-1:0] wi_q   [NUM_TABLES];
	logic [CNT_W-1:0] cnt_q  [NUM_TABLES];
	logic [WRD_W-1:0] size_q [NUM_TABLES];
	logic [NUM_TABLES-1:0] closed_q;
	logic [MAX_COMMANDS-1:0] flag_q [NUM_TABLES];

	logic             ov_q;
	logic [2:0]       o_status_q;
	logic [CMD_W-1:0] o_cmd_q;
	logic [WRD_W-1:0] o_off_q;
	logic [31:0]      o_time_q;
	logic [CNT_W-1:0] o_cnt_q;
	logic [WRD_W-1:0] o_words_q;
	logic             rd_ok_q;

	logic [TW-1:0]     t;
	logic              tbl_ok;
	logic [WRD_W-1:0]  wi;
	logic [CNT_W-1:0]  cnt;
	logic [16:0]       words17, sum17;
	logic [CIDX_W-1:0] cmd_idx;
	key_t              new_key, rd_key;
	logic              rd_ok;

	status_t           r_status;
	logic [WRD_W-1:0]  r_off, r_words;
	logic [CNT_W-1:0]  r_cnt;
	logic do_clear, do_open, do_close, do_ins, do_size;
	logic [WRD_W-1:0]  size_val;
	logic fin, fail;

	logic [WRD_W-1:0]  ram_rdata;
	logic [AW-1:0]     ram_waddr, ram_raddr;

	key_t ckey [MAX_COMMANDS];
	logic [MAX_COMMANDS-1:0] cgt;

	assign s_axis_tready = (st_q == FSM_IDLE) && !ov_q;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tuser = o_status_q;
	assign m_axis_tdata = {o_words_q, o_cnt_q, o_time_q, o_off_q, o_cmd_q};

	assign t = TW'(sel_q);
	assign tbl_ok = (32'(sel_q) < NUM_TABLES);
	assign wi = wi_q[t];
	assign cnt = cnt_q[t];
	assign words17 = (17'(bytes_q) + 17'(HEADER_BYTES + 1)) >> 1;
	assign sum17 = 17'(wi) + words17;
	assign cmd_idx = CIDX_W'(cmd_q - 16'd1);
	assign new_key.cmd = cmd_q[CMD_W-1:0];
	assign new_key.tm = time_q;
	assign rd_key = ckey[pos_q];
	assign rd_ok = (7'(pos_q) < cnt);
	assign ram_waddr = {t, cmd_idx};
	assign ram_raddr = {t, CIDX_W'(rd_key.cmd - 7'd1)};

	genvar k;
	generate
		for (k = 0; k < MAX_COMMANDS; k++) begin : g_cell
			key_t lk;
			logic lg;
			if (k == 0) begin : g_head
				assign lk = '0;
				assign lg = 1'b0;
			end else begin : g_body
				assign lk = ckey[k-1];
				assign lg = cgt[k-1];
			end
			ats_cell #(.NUM_TABLES(NUM_TABLES)) u_cell (
				.clk      (clk),
				.ins      (do_ins),
				.tbl      (t),
				.new_key  (new_key),
				.occupied (CNT_W'(k) < cnt),
				.tail     (CNT_W'(k) == cnt),
				.left_key (lk),
				.left_gt  (lg),
				.key      (ckey[k]),
				.gt       (cgt[k])
			);
		end
	endgenerate

	ats_ram #(.WIDTH(WRD_W), .DEPTH(2 ** AW)) u_off_ram (
		.clk   (clk),
		.we    (do_ins),
		.waddr (ram_waddr),
		.wdata (wi),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		r_status = ST_IGNORED;
		r_off = '0;
		r_words = '0;
		r_cnt = '0;
		do_clear = 1'b0;
		do_open = 1'b0;
		do_close = 1'b0;
		do_ins = 1'b0;
		do_size = 1'b0;
		size_val = wi;
		fin = 1'b0;
		fail = 1'b0;
		st_d = st_q;
		case (st_q)
			FSM_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) begin
					st_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				st_d = FSM_IDLE;
				case (action_t'(act_q))
					ACT_CLEAR: begin
						if (tbl_ok) begin
							do_clear = 1'b1;
							do_open = 1'b1;
							r_status = ST_ACCEPT;
						end
					end
					ACT_LOAD: begin
						if (tbl_ok && !closed_q[t]) begin
							if (32'(wi) >= BUFFER_WORDS) begin
								fin = (32'(wi) == BUFFER_WORDS);
								fail = !fin;
							end else if (cmd_q == '0) begin
								fin = 1'b1;
							end else if (32'(wi) > BUFFER_WORDS - MIN_ENTRY_WORDS) begin
								fail = 1'b1;
							end else if (32'(cmd_q) > MAX_COMMANDS || flag_q[t][cmd_idx]) begin
								fail = 1'b1;
							end else if (bytes_q < min_q || bytes_q > max_q) begin
								fail = 1'b1;
							end else if (32'(sum17) > BUFFER_WORDS) begin
								fail = 1'b1;
							end else if (32'(cnt) < MAX_COMMANDS) begin
								do_ins = 1'b1;
								r_off = wi;
								r_cnt = cnt + 7'd1;
								r_words = sum17[WRD_W-1:0];
								if (32'(sum17) == BUFFER_WORDS) begin
									// exact fill closes the load at once
									do_close = 1'b1;
									do_size = 1'b1;
									size_val = sum17[WRD_W-1:0];
									r_status = ST_DONE;
								end else begin
									r_status = ST_ACCEPT;
								end
							end
							if (fin) begin
								do_close = 1'b1;
								if (cnt != '0) begin
									do_size = 1'b1;
									r_status = ST_DONE;
									r_words = wi;
									r_cnt = cnt;
								end else begin
									do_clear = 1'b1;
									r_status = ST_EMPTY;
								end
							end
							if (fail) begin
								do_close = 1'b1;
								do_clear = 1'b1;
								r_status = ST_ERROR;
							end
						end
					end
					ACT_READ: begin
						if (tbl_ok) begin
							r_status = ST_READ;
							r_cnt = cnt;
							r_words = size_q[t];
							st_d = FSM_RD;
						end
					end
					default: begin
					end
				endcase
			end
			FSM_RD: begin
				st_d = FSM_IDLE;
			end
			default: begin
				st_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FSM_IDLE;
			ov_q <= 1'b0;
			min_q <= 16'd8;
			max_q <= 16'd256;
			closed_q <= '1;
			for (int i = 0; i < NUM_TABLES; i++) begin
				wi_q[i] <= '0;
				cnt_q[i] <= '0;
				size_q[i] <= '0;
				flag_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_BYTES: min_q <= cfg_data;
					REG_MAX_BYTES: max_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				ov_q <= 1'b0;
			end
			if (st_q == FSM_EXEC && st_d == FSM_IDLE) begin
				ov_q <= 1'b1;
			end
			if (st_q == FSM_RD) begin
				ov_q <= 1'b1;
			end
			if (do_open) begin
				closed_q[t] <= 1'b0;
			end
			if (do_close) begin
				closed_q[t] <= 1'b1;
			end
			if (do_ins) begin
				flag_q[t][cmd_idx] <= 1'b1;
				cnt_q[t] <= cnt + 7'd1;
				wi_q[t] <= sum17[WRD_W-1:0];
			end
			if (do_size) begin
				size_q[t] <= size_val;
			end
			if (do_clear) begin
				wi_q[t] <= '0;
				cnt_q[t] <= '0;
				size_q[t] <= '0;
				flag_q[t] <= '0;
			end
		end
	end

	// input capture and result payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			act_q <= s_axis_tuser[1:0];
			sel_q <= s_axis_tuser[2];
			cmd_q <= s_axis_tdata[15:0];
			bytes_q <= s_axis_tdata[31:16];
			time_q <= s_axis_tdata[63:32];
			pos_q <= s_axis_tdata[69:64];
		end
		if (st_q == FSM_EXEC) begin
			o_status_q <= r_status;
			o_off_q <= r_off;
			o_cnt_q <= r_cnt;
			o_words_q <= r_words;
			rd_ok_q <= rd_ok;
			if (st_d == FSM_RD && rd_ok) begin
				o_cmd_q <= rd_key.cmd;
				o_time_q <= rd_key.tm;
			end else begin
				o_cmd_q <= '0;
				o_time_q <= '0;
			end
		end
		if (st_q == FSM_RD) begin
			o_off_q <= rd_ok_q ? ram_rdata : '0;
		end
	end

endmodule
